// ===== sv/dtu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types and constants for the day-of-year time line to Unix converter.
// ----------------------------------------------------------------------------
package dtu_pkg;

  // Request on the character channel
  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } char_req_t;

  // Request on the timestamp channel
  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [1:0]  line_status;
  } time_rsp_t;

  // Line status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_MALFORMED = 2'd2;
  localparam logic [1:0] STATUS_RANGE     = 2'd3;

  // Parser phases
  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_YEAR  = 4'd1,
    PH_DOY   = 4'd2,
    PH_HOUR  = 4'd3,
    PH_SEP1  = 4'd4,
    PH_MIN   = 4'd5,
    PH_SEP2  = 4'd6,
    PH_SEC   = 4'd7,
    PH_DONE  = 4'd8,
    PH_FAULT = 4'd9
  } phase_t;

  // Field width and limits
  localparam int unsigned FIELD_W = 14;

  localparam logic [FIELD_W-1:0] ACC_MAX     = 14'd16383;
  localparam logic [FIELD_W-1:0] YEAR_MIN    = 14'd1970;
  localparam logic [FIELD_W-1:0] YEAR_MAX    = 14'd2100;
  localparam logic [FIELD_W-1:0] DOY_LEAP    = 14'd366;
  localparam logic [FIELD_W-1:0] DOY_COMMON  = 14'd365;
  localparam logic [FIELD_W-1:0] HOUR_MAX    = 14'd23;
  localparam logic [FIELD_W-1:0] MIN_SEC_MAX = 14'd59;

  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;

  // Parsed line handed from the parser to the converter
  typedef struct packed {
    logic [1:0]         pre_status;
    logic [FIELD_W-1:0] year;
    logic [FIELD_W-1:0] doy;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
  } fields_t;

endpackage

// ===== sv/dtu_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtu_parser
// Character parser: walks the time line one byte per request and hands the
// finished fields with a preliminary status to the snapshot register.
// ----------------------------------------------------------------------------
module dtu_parser
  import dtu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  char_req_t char_req,
  output logic      snap_valid,
  output fields_t   snap,
  input  logic      snap_ready
);

  phase_t             phase, phase_next;
  logic [FIELD_W-1:0] acc, acc_next;
  logic               has_digit, has_digit_next;
  logic [FIELD_W-1:0] year, year_next;
  logic [FIELD_W-1:0] doy, doy_next;
  logic [FIELD_W-1:0] hour, hour_next;
  logic [FIELD_W-1:0] minute, minute_next;
  logic [1:0]         err, err_next;

  logic               accept;
  logic               is_digit, is_blank, is_lead;
  logic [17:0]        acc_prod;
  logic [FIELD_W-1:0] acc_add;
  logic [FIELD_W-1:0] acc_field;
  logic [1:0]         pre_status;

  // Hold requests only while the snapshot cannot move on
  assign char_stall = snap_valid && !snap_ready;
  assign accept     = char_valid && !char_stall;

  // Classify the byte
  assign is_digit = (char_req.char_byte >= 8'h30) && (char_req.char_byte <= 8'h39);
  assign is_blank = (char_req.char_byte == 8'h20) ||
                    ((char_req.char_byte >= 8'h09) && (char_req.char_byte <= 8'h0D));
  assign is_lead  = (char_req.char_byte == 8'h20) || (char_req.char_byte == 8'h09) ||
                    (char_req.char_byte == 8'h0A) || (char_req.char_byte == 8'h0D);

  // Accumulate one decimal digit, saturating
  assign acc_prod = 18'(acc) * 18'd10 + 18'(char_req.char_byte[3:0]);
  assign acc_add  = (acc_prod > 18'(ACC_MAX)) ? ACC_MAX : acc_prod[FIELD_W-1:0];

  // Next phase and field updates
  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    has_digit_next = has_digit;
    year_next      = year;
    doy_next       = doy;
    hour_next      = hour;
    minute_next    = minute;
    err_next       = err;
    acc_field      = acc;
    unique case (phase)
      PH_START: begin
        if (is_digit) begin
          phase_next     = PH_YEAR;
          acc_next       = acc_add;
          has_digit_next = 1'b1;
        end else if (!is_lead) begin
          phase_next = PH_FAULT;
          err_next   = STATUS_EMPTY;
        end
      end
      PH_YEAR, PH_DOY: begin
        if (is_digit) begin
          acc_next       = acc_add;
          has_digit_next = 1'b1;
        end else if (is_blank) begin
          if (has_digit) begin
            if (phase == PH_YEAR) begin
              year_next  = acc_field;
              phase_next = PH_DOY;
            end else begin
              doy_next   = acc_field;
              phase_next = PH_HOUR;
            end
            acc_next       = '0;
            has_digit_next = 1'b0;
          end
        end else begin
          phase_next = PH_FAULT;
          err_next   = STATUS_MALFORMED;
        end
      end
      PH_HOUR, PH_MIN: begin
        if (is_digit) begin
          acc_next       = acc_add;
          has_digit_next = 1'b1;
        end else if (!has_digit) begin
          if (!is_blank) begin
            phase_next = PH_FAULT;
            err_next   = STATUS_MALFORMED;
          end
        end else begin
          // A non-blank ends the number and is the separator itself
          if (phase == PH_HOUR) begin
            hour_next  = acc_field;
            phase_next = is_blank ? PH_SEP1 : PH_MIN;
          end else begin
            minute_next = acc_field;
            phase_next  = is_blank ? PH_SEP2 : PH_SEC;
          end
          acc_next       = '0;
          has_digit_next = 1'b0;
        end
      end
      PH_SEP1, PH_SEP2: begin
        if (!is_blank) begin
          phase_next = (phase == PH_SEP1) ? PH_MIN : PH_SEC;
        end
      end
      PH_SEC: begin
        if (is_digit) begin
          acc_next       = acc_add;
          has_digit_next = 1'b1;
        end else if (has_digit) begin
          phase_next = PH_DONE;
        end else if (!is_blank) begin
          phase_next = PH_FAULT;
          err_next   = STATUS_MALFORMED;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        if (err == STATUS_OK) begin
          err_next = STATUS_MALFORMED;
        end
        phase_next = PH_FAULT;
      end
    endcase
  end

  // Grade the line as it stands after this byte
  always_comb begin
    if (phase_next == PH_START) begin
      pre_status = STATUS_EMPTY;
    end else if (err_next != STATUS_OK) begin
      pre_status = err_next;
    end else if (!((phase_next == PH_DONE) ||
                   ((phase_next == PH_SEC) && has_digit_next))) begin
      pre_status = STATUS_MALFORMED;
    end else begin
      pre_status = STATUS_OK;
    end
  end

  // Parser state: advance per request, clear at each line end
  always_ff @(posedge clk) begin
    if (rst || (accept && char_req.line_end)) begin
      phase     <= PH_START;
      acc       <= '0;
      has_digit <= 1'b0;
      year      <= '0;
      doy       <= '0;
      hour      <= '0;
      minute    <= '0;
      err       <= STATUS_OK;
    end else if (accept) begin
      phase     <= phase_next;
      acc       <= acc_next;
      has_digit <= has_digit_next;
      year      <= year_next;
      doy       <= doy_next;
      hour      <= hour_next;
      minute    <= minute_next;
      err       <= err_next;
    end
  end

  // Snapshot register: load on line end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && char_req.line_end) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && char_req.line_end) begin
      snap.pre_status <= pre_status;
      snap.year       <= year_next;
      snap.doy        <= doy_next;
      snap.hour       <= hour_next;
      snap.minute     <= minute_next;
      snap.second     <= acc_next;
    end
  end

endmodule

// ===== sv/dtu_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtu_convert
// Range check and conversion to Unix seconds in two registered stages.
// ----------------------------------------------------------------------------
module dtu_convert
  import dtu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      snap_valid,
  input  fields_t   snap,
  output logic      snap_ready,
  output logic      time_valid,
  input  logic      time_stall,
  output time_rsp_t time_rsp
);

  logic        out_ready;
  logic        mid_ready;

  logic        mid_valid;
  logic [1:0]  mid_status;
  logic [15:0] mid_days;
  logic [16:0] mid_hms;

  logic        year_ok, leap, doy_ok, clock_ok;
  logic [FIELD_W-1:0] doy_max;
  logic [FIELD_W-1:0] year_ofs;
  logic [8:0]  year_inc;
  logic [15:0] days;
  logic [16:0] hms;
  logic [1:0]  status;
  logic [32:0] total;

  // Per-stage ready
  assign out_ready  = !time_valid || !time_stall;
  assign mid_ready  = !mid_valid || out_ready;
  assign snap_ready = mid_ready;

  // Range checks; within 1970..2100 only 2100 breaks the every-fourth-year rule
  assign year_ok  = (snap.year >= YEAR_MIN) && (snap.year <= YEAR_MAX);
  assign leap     = (snap.year[1:0] == 2'b00) && (snap.year != YEAR_MAX);
  assign doy_max  = leap ? DOY_LEAP : DOY_COMMON;
  assign doy_ok   = (snap.doy != '0) && (snap.doy <= doy_max);
  assign clock_ok = (snap.hour <= HOUR_MAX) && (snap.minute <= MIN_SEC_MAX) &&
                    (snap.second <= MIN_SEC_MAX);

  // Day count since the epoch; leap days before year y are (y - 1969) / 4
  assign year_ofs = snap.year - YEAR_MIN;
  assign year_inc = {1'b0, year_ofs[7:0]} + 9'd1;
  assign days     = 16'(year_ofs[7:0]) * 16'(DAYS_PER_YEAR) + 16'(year_inc[8:2]) +
                    16'(snap.doy[8:0]) - 16'd1;
  assign hms      = 17'(snap.hour[4:0]) * 17'(SEC_PER_HOUR) +
                    17'(snap.minute[5:0]) * 17'(SEC_PER_MIN) + 17'(snap.second[5:0]);

  always_comb begin
    if (snap.pre_status != STATUS_OK) begin
      status = snap.pre_status;
    end else if (!(year_ok && doy_ok && clock_ok)) begin
      status = STATUS_RANGE;
    end else begin
      status = STATUS_OK;
    end
  end

  // Middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_ready) begin
      mid_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && snap_valid) begin
      mid_status <= status;
      mid_days   <= days;
      mid_hms    <= hms;
    end
  end

  // Final seconds; a zero timestamp is rejected
  assign total = 33'(mid_days) * 33'(SEC_PER_DAY) + 33'(mid_hms);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid <= 1'b0;
    end else if (out_ready) begin
      time_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && mid_valid) begin
      if (mid_status != STATUS_OK) begin
        time_rsp.unix_seconds <= '0;
        time_rsp.line_status  <= mid_status;
      end else if (total[31:0] == '0) begin
        time_rsp.unix_seconds <= '0;
        time_rsp.line_status  <= STATUS_RANGE;
      end else begin
        time_rsp.unix_seconds <= total[31:0];
        time_rsp.line_status  <= STATUS_OK;
      end
    end
  end

endmodule

// ===== sv/ascii_day_of_year_time_to_unix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_day_of_year_time_to_unix
// Parses an ASCII "YYYY DDD HH:MM:SS" line into Unix seconds and a status.
// ----------------------------------------------------------------------------
// Usage:
//   The char channel (char_valid, char_stall, char_req) takes one byte of the
//   time line per request; char_req.line_end marks the last byte of a line.
//   Each byte is parsed in the cycle it is taken, so one byte per cycle is
//   sustained while char_stall is low. The time channel (time_valid,
//   time_stall, time_rsp) returns exactly one request per line:
//   unix_seconds and line_status. After the line-end byte a line passes the
//   snapshot register, check stage (range checks, day count, seconds of day)
//   and output register (days times 86400 plus seconds of day) to time_valid.
//   Each stage moves when the one after it is empty or moving, so the block
//   keeps taking bytes while a result waits; char_stall rises only when all
//   three stages hold lines and time_stall is high.
//   Reset (rst, synchronous) returns the parser to the start of a line and
//   empties all stages; no result is pending after reset.
// ----------------------------------------------------------------------------
module ascii_day_of_year_time_to_unix
  import dtu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  char_req_t char_req,
  output logic      time_valid,
  input  logic      time_stall,
  output time_rsp_t time_rsp
);

  logic    snap_valid;
  logic    snap_ready;
  fields_t snap;

  dtu_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_req   (char_req),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  dtu_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .time_valid (time_valid),
    .time_stall (time_stall),
    .time_rsp   (time_rsp)
  );

`ifndef SYNTH
  // A line end always lands in the snapshot register
  a_line_end_snap: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_stall && char_req.line_end) |=> snap_valid)
    else $error("line end not captured");

  // A good line never reports a zero timestamp
  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    (time_valid && (time_rsp.line_status == STATUS_OK)) |-> (time_rsp.unix_seconds != '0))
    else $error("ok status with zero seconds");

  // A rejected line reports zero seconds
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (time_valid && (time_rsp.line_status != STATUS_OK)) |-> (time_rsp.unix_seconds == '0))
    else $error("error status with nonzero seconds");
`endif

endmodule

// ===== sim/dtu_line_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtu_line_checker
// Watches both channels of the time line converter and predicts each stamp.
// Every accepted character is parsed by a local copy of the line parser. On a
// line end the expected stamp is queued, and each accepted stamp is compared
// field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module dtu_line_checker
  import dtu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  input  logic      char_stall,
  input  char_req_t char_req,
  input  logic      time_valid,
  input  logic      time_stall,
  input  time_rsp_t time_rsp,
  output int        fail_count,
  output int        lines_pending
);

  localparam int unsigned EPOCH_YEAR         = 1970;
  localparam int unsigned LEAPS_BEFORE_EPOCH = 477;
  localparam int          REPORT_LIMIT       = 10;

  // Parser state of the predictor
  phase_t             ph;
  logic [FIELD_W-1:0] acc;
  logic               got_digit;
  logic [FIELD_W-1:0] yr;
  logic [FIELD_W-1:0] doy;
  logic [FIELD_W-1:0] hr;
  logic [FIELD_W-1:0] mi;
  logic [1:0]         err;

  time_rsp_t stamp_q[$];

  initial begin
    fail_count    = 0;
    lines_pending = 0;
  end

  function automatic logic is_lead(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Return to the start of a line
  function automatic void clear_line();
    ph        = PH_START;
    acc       = '0;
    got_digit = 1'b0;
    yr        = '0;
    doy       = '0;
    hr        = '0;
    mi        = '0;
    err       = STATUS_OK;
  endfunction

  // Accumulate one decimal digit, saturating at the field maximum
  function automatic void take_digit(input logic [7:0] c);
    int unsigned v;
    v = acc * 32'd10 + c - 32'd48;
    acc = (v > 32'(ACC_MAX)) ? ACC_MAX : v[FIELD_W-1:0];
    got_digit = 1'b1;
  endfunction

  function automatic void open_next_field();
    acc       = '0;
    got_digit = 1'b0;
  endfunction

  function automatic void raise_fault(input logic [1:0] code);
    err = code;
    ph  = PH_FAULT;
  endfunction

  // Advance the parser by one character
  function automatic void parse_byte(input logic [7:0] c);
    case (ph)
      PH_START: begin
        if (is_digit(c)) begin
          ph = PH_YEAR;
          take_digit(c);
        end else if (!is_lead(c)) begin
          raise_fault(STATUS_EMPTY);
        end
      end
      PH_YEAR, PH_DOY: begin
        if (is_digit(c)) begin
          take_digit(c);
        end else if (is_blank(c)) begin
          if (got_digit) begin
            if (ph == PH_YEAR) begin
              yr = acc;
              ph = PH_DOY;
            end else begin
              doy = acc;
              ph  = PH_HOUR;
            end
            open_next_field();
          end
        end else begin
          raise_fault(STATUS_MALFORMED);
        end
      end
      PH_HOUR, PH_MIN: begin
        if (is_digit(c)) begin
          take_digit(c);
        end else if (!got_digit) begin
          if (!is_blank(c)) raise_fault(STATUS_MALFORMED);
        end else if (ph == PH_HOUR) begin
          hr = acc;
          ph = is_blank(c) ? PH_SEP1 : PH_MIN;
          open_next_field();
        end else begin
          mi = acc;
          ph = is_blank(c) ? PH_SEP2 : PH_SEC;
          open_next_field();
        end
      end
      PH_SEP1, PH_SEP2: begin
        if (!is_blank(c)) ph = (ph == PH_SEP1) ? PH_MIN : PH_SEC;
      end
      PH_SEC: begin
        if (is_digit(c)) take_digit(c);
        else if (got_digit) ph = PH_DONE;
        else if (!is_blank(c)) raise_fault(STATUS_MALFORMED);
      end
      PH_DONE: begin
      end
      default: begin
        if (err == STATUS_OK) err = STATUS_MALFORMED;
        ph = PH_FAULT;
      end
    endcase
  endfunction

  // Range check the parsed fields and convert them to Unix seconds
  function automatic time_rsp_t line_stamp();
    time_rsp_t   r;
    int unsigned y, d, h, m, s, p, days, t;
    logic        leap;
    y = yr;
    d = doy;
    h = hr;
    m = mi;
    s = acc;
    leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    r.unix_seconds = '0;
    r.line_status  = STATUS_OK;
    if (ph == PH_START) begin
      r.line_status = STATUS_EMPTY;
    end else if (err != STATUS_OK) begin
      r.line_status = err;
    end else if (!(ph == PH_DONE || (ph == PH_SEC && got_digit))) begin
      r.line_status = STATUS_MALFORMED;
    end else if (y < YEAR_MIN || y > YEAR_MAX) begin
      r.line_status = STATUS_RANGE;
    end else if (d < 1 || d > (leap ? DOY_LEAP : DOY_COMMON)) begin
      r.line_status = STATUS_RANGE;
    end else if (h > HOUR_MAX || m > MIN_SEC_MAX || s > MIN_SEC_MAX) begin
      r.line_status = STATUS_RANGE;
    end else begin
      p = y - 1;
      days = 365 * (y - EPOCH_YEAR) + (p / 4 - p / 100 + p / 400)
             - LEAPS_BEFORE_EPOCH + (d - 1);
      t = days * 86400 + h * 3600 + m * 60 + s;
      if (t == 0) r.line_status = STATUS_RANGE;
      else r.unix_seconds = t;
    end
    return r;
  endfunction

  // Check stamps first so a line ending at this edge cannot match itself
  always @(posedge clk) begin
    time_rsp_t want;
    if (rst) begin
      clear_line();
      stamp_q.delete();
    end else begin
      if (time_valid && !time_stall) begin
        if (stamp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: stamp with none expected: seconds %0d status %0d",
                     $realtime, time_rsp.unix_seconds, time_rsp.line_status);
        end else begin
          want = stamp_q.pop_front();
          if (time_rsp.unix_seconds !== want.unix_seconds ||
              time_rsp.line_status !== want.line_status) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("%0t: stamp mismatch: expected seconds %0d status %0d, got seconds %0d status %0d",
                       $realtime, want.unix_seconds, want.line_status,
                       time_rsp.unix_seconds, time_rsp.line_status);
          end
        end
      end
      if (char_valid && !char_stall) begin
        parse_byte(char_req.char_byte);
        if (char_req.line_end) begin
          stamp_q.push_back(line_stamp());
          clear_line();
        end
      end
    end
    lines_pending <= stamp_q.size();
  end

endmodule

// ===== sim/tb_ascii_day_of_year_time_to_unix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_day_of_year_time_to_unix
// Drives time lines into the converter and gives the verdict.
// A directed set of lines covers field extremes, lead and blank handling,
// faults, saturation and the zero stamp; then random lines, mostly well
// formed with random content, some broken or pure noise. Both channels idle
// at random, the stamp side holds off once long enough to stall the input,
// and the sender once waits for every stamp. The checker does the compare.
// ----------------------------------------------------------------------------
module tb_ascii_day_of_year_time_to_unix;
  import dtu_pkg::*;

  localparam int RANDOM_BYTES   = 1175;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk        = 1'b0;
  logic      rst        = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_stall;
  char_req_t char_req   = '0;
  logic      time_valid;
  logic      time_stall = 1'b0;
  time_rsp_t time_rsp;

  int fail_count;
  int lines_pending;

  logic calm      = 1'b0;
  logic hold_go   = 1'b0;
  bit   hold_done = 1'b0;
  int   idle_cycles = 0;
  int   n_sent      = 0;

  logic [7:0] line_buf[$];

  ascii_day_of_year_time_to_unix dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_req   (char_req),
    .time_valid (time_valid),
    .time_stall (time_stall),
    .time_rsp   (time_rsp)
  );

  dtu_line_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_req      (char_req),
    .time_valid    (time_valid),
    .time_stall    (time_stall),
    .time_rsp      (time_rsp),
    .fail_count    (fail_count),
    .lines_pending (lines_pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (time_valid && !time_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ascii_day_of_year_time_to_unix test failed");
      $finish;
    end
  end

  // Stamp side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rst) begin
        time_stall <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        time_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        time_stall <= 1'b0;
      end else begin
        time_stall <= !calm && ($urandom_range(99) < 8);
      end
    end
  end

  // Offer one character and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 8) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_req   <= '{char_byte: b, line_end: last};
    @(posedge clk);
    while (char_stall) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  function automatic void push_str(input string s);
    foreach (s[i]) line_buf.push_back(s[i]);
  endfunction

  task automatic send_text(input string s);
    line_buf.delete();
    push_str(s);
    send_line();
  endtask

  // Drop the input and wait until every stamp has come back
  task automatic wait_all_stamps();
    char_valid <= 1'b0;
    @(posedge clk);
    while (lines_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_lead();
    case ($urandom_range(3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    int k;
    k = $urandom_range(9);
    return (k > 4) ? 8'h20 : 8'h09 + 8'(k);
  endfunction

  function automatic logic [7:0] rand_nonblank();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic void push_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) line_buf.push_back(rand_blank());
  endfunction

  // Decimal number, now and then with leading zeros
  function automatic void push_num(input int unsigned n);
    if ($urandom_range(9) == 0) repeat ($urandom_range(3, 1)) line_buf.push_back("0");
    push_str($sformatf("%0d", n));
  endfunction

  function automatic void push_sep();
    if ($urandom_range(9) < 8) line_buf.push_back(":");
    else line_buf.push_back(rand_nonblank());
  endfunction

  function automatic void push_inner_blanks();
    if ($urandom_range(3) == 0) push_blanks(1, 2);
  endfunction

  // Well formed line with random content, mostly in range
  function automatic void build_time_line();
    int k;
    line_buf.delete();
    if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) line_buf.push_back(rand_lead());
    k = $urandom_range(9);
    if (k < 7) push_num($urandom_range(2100, 1970));
    else if (k == 7) push_num($urandom_range(1969, 1900));
    else if (k == 8) push_num($urandom_range(2300, 2101));
    else push_num($urandom_range(99999));
    push_blanks(1, 2);
    k = $urandom_range(9);
    if (k < 8) push_num($urandom_range(365, 1));
    else if (k == 8) push_num(366);
    else push_num($urandom_range(999));
    push_blanks(1, 2);
    push_num(($urandom_range(9) < 8) ? $urandom_range(23) : $urandom_range(99));
    push_inner_blanks();
    push_sep();
    push_inner_blanks();
    push_num(($urandom_range(9) < 8) ? $urandom_range(59) : $urandom_range(99));
    push_inner_blanks();
    push_sep();
    push_inner_blanks();
    push_num(($urandom_range(9) < 8) ? $urandom_range(59) : $urandom_range(99));
    k = $urandom_range(3);
    if (k == 1) begin
      push_str(" +00");
    end else if (k == 2) begin
      repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Corrupt, cut short or replace the line in the buffer
  function automatic void break_line();
    int n;
    case ($urandom_range(3))
      0: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
      1: begin
        n = $urandom_range(line_buf.size() - 1, 1);
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
      2: begin
        line_buf.delete();
        repeat ($urandom_range(12, 1)) line_buf.push_back(8'($urandom_range(255)));
      end
      default: begin
        line_buf.delete();
        repeat ($urandom_range(4, 1)) line_buf.push_back(rand_lead());
      end
    endcase
  endfunction

  initial begin
    int line_no;
    int start_count;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines: extremes, leads, faults, saturation, zero stamp
    send_text("1970 001 00:00:01");
    send_text("1970 001 00:00:00");
    send_text("2100 365 23:59:59 +00");
    send_text("2000 366 12:34:56");
    send_text("2024 366 01:02:03");
    send_text("2100 366 00:00:00");
    send_text("1969 365 23:59:59");
    send_text(" \011\015\0121999 200 10 : 20 - 30");
    send_text("\0132020 100 10:20:30");
    send_text("\0142020 100 10:20:30");
    send_text("+2020 100 10:20:30");
    send_text("   ");
    line_buf.delete();
    line_buf.push_back(8'h00);
    send_line();
    send_text("2020 -100 10:00:00");
    send_text("2020x100 10:00:00");
    send_text("2020 100x10:00:00");
    send_text("2020 100 10:20");
    send_text("123456 100 10:20:30");
    send_text("2020 100 99999:00:00");
    send_text("2020 000 00:00:00");
    send_text("2020 100 24:00:00");
    send_text("2020 100 23:60:00");
    send_text("2020 100 23:59:60");
    send_text("2020\015100\01310 5 30 7 45");
    line_buf.delete();
    push_str("2020 100 10:20:30");
    line_buf.push_back(8'hFF);
    send_line();

    // Random lines with one hold-off, one full pause and one calm stretch
    line_no = 0;
    start_count = n_sent;
    while (n_sent - start_count < RANDOM_BYTES) begin
      calm <= (line_no >= 24 && line_no < 40);
      if (line_no == 20) begin
        hold_go <= 1'b1;
        repeat (12) begin
          line_buf.delete();
          line_buf.push_back(8'h30 + 8'($urandom_range(9)));
          send_line();
        end
      end else if (line_no == 40) begin
        wait_all_stamps();
      end
      build_time_line();
      if ($urandom_range(99) < 20) break_line();
      send_line();
      line_no++;
    end

    wait_all_stamps();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && lines_pending == 0) begin
      $display("ascii_day_of_year_time_to_unix test passed");
    end else begin
      $display("ascii_day_of_year_time_to_unix test failed");
    end
    $finish;
  end

endmodule
